FILE: rtl/core/ftpc_pkg.sv
// Shared types and constants for the flow table packet counter.
// Depends on nothing; every other file of the block imports it.
package ftpc_pkg;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int COUNT_W  = 31;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_CLOSE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT     = 3'd0,
    STATUS_ADDED   = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_REMOVED = 3'd3,
    STATUS_MISSED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // A lookup request as it walks from cell to cell.
  typedef struct packed {
    logic               live;
    opcode_t            op;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic               found;
    logic               free_seen;
    logic [COUNT_W-1:0] count;
  } token_t;

  // Allocation order sent from the top level to every cell at the end of a walk.
  typedef struct packed {
    logic              add;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } commit_t;

endpackage

FILE: rtl/core/ftpc_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ftpc_pkg for the field widths.
interface ftpc_req_if;
  import ftpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] client_address;
  logic [PORT_W-1:0] src_port;

  modport source (output valid, output opcode, output client_address,
                  output src_port, input ready);
  modport sink (input valid, input opcode, input client_address,
                input src_port, output ready);
endinterface

interface ftpc_rsp_if;
  import ftpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  packet_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output packet_count, output status, input ready);
  modport sink (input valid, input packet_count, input status, output ready);
endinterface

FILE: rtl/core/ftpc_cell.sv
// One flow table entry and the stage that hands a lookup on to the next entry.
// Depends on ftpc_pkg for the token and commit types.
module ftpc_cell (
  input  logic              clk,
  input  logic              rst,
  input  ftpc_pkg::token_t  tok_in,
  input  ftpc_pkg::commit_t commit,
  output ftpc_pkg::token_t  tok_out
);
  import ftpc_pkg::*;

  logic               valid;
  logic [ADDR_W-1:0]  addr;
  logic [PORT_W-1:0]  port;
  logic [COUNT_W-1:0] cnt;
  logic               claim;

  logic               hit;
  logic               first_free;
  logic [COUNT_W-1:0] cnt_inc;
  token_t             tok_next;

  assign hit = tok_in.live && valid && !tok_in.found &&
               (addr == tok_in.addr) && (port == tok_in.port);
  assign first_free = tok_in.live && !valid && !tok_in.free_seen;
  assign cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);

  always_comb begin
    tok_next = tok_in;
    if (first_free) begin
      tok_next.free_seen = 1'b1;
    end
    if (hit) begin
      tok_next.found = 1'b1;
      if (tok_in.op == OP_COUNT) begin
        tok_next.count = cnt_inc;
      end else begin
        tok_next.count = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      claim   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      // Each walk re-decides which cell would take a new key.
      if (tok_in.live) begin
        claim <= first_free;
      end
      if (commit.add && claim) begin
        valid <= 1'b1;
      end else if (hit && tok_in.op == OP_CLOSE) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit.add && claim) begin
      addr <= commit.addr;
      port <= commit.port;
      cnt  <= COUNT_W'(1);
    end else if (hit && tok_in.op == OP_COUNT) begin
      cnt <= cnt_inc;
    end
  end

endmodule

FILE: rtl/core/flow_table_packet_counter.sv
// Per-flow packet counter: request and response channels around a row of
// table cells. A request sent into req walks through every cell, one per
// cycle, and each cell compares the key against its own entry.
// A count request bumps the matching counter (saturating at 2^31-1) or, on
// a miss, takes the lowest free entry with a count of one; status 2 tells
// that the table is full. A close request frees the matching entry
// (status 3) or reports a miss (status 4); packet_count is zero then.
// The response is registered once the walk through the cell row is done;
// one request is in flight at a time, so a new request is taken only after
// the response to the last one has been loaded into the output register.
// A response that rsp does not take waits in the output register; the next
// request can still walk the table and holds at the end of the row until
// the output register frees.
// Reset (rst, synchronous) empties the table at once and drops any request
// in flight; no clearing pass is needed.
// Depends on ftpc_pkg, ftpc_if and ftpc_cell.
module flow_table_packet_counter #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic      clk,
  input  logic      rst,
  ftpc_req_if.sink  req,
  ftpc_rsp_if.source rsp
);
  import ftpc_pkg::*;

  state_t  state;
  state_t  state_next;
  token_t  head;
  token_t  tok [0:TABLE_ENTRIES];
  token_t  fin;
  commit_t commit;

  logic                req_take;
  logic                load_out;
  logic                out_valid;
  logic [COUNT_W-1:0]  out_count;
  status_t             out_status;
  logic [COUNT_W-1:0]  res_count;
  status_t             res_status;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok[TABLE_ENTRIES].live) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The walk has finished by now; decide the outcome from the final token.
  always_comb begin
    res_count  = '0;
    commit.add = 1'b0;
    commit.addr = fin.addr;
    commit.port = fin.port;
    if (fin.op == OP_CLOSE) begin
      res_status = fin.found ? STATUS_REMOVED : STATUS_MISSED;
    end else if (fin.found) begin
      res_status = STATUS_HIT;
      res_count  = fin.count;
    end else if (fin.free_seen) begin
      res_status = STATUS_ADDED;
      res_count  = COUNT_W'(1);
      commit.add = load_out;
    end else begin
      res_status = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (req_take) begin
        head.live      <= 1'b1;
        head.op        <= opcode_t'(req.opcode);
        head.addr      <= req.client_address;
        head.port      <= req.src_port;
        head.found     <= 1'b0;
        head.free_seen <= 1'b0;
        head.count     <= '0;
      end else begin
        head.live <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && tok[TABLE_ENTRIES].live) begin
      fin <= tok[TABLE_ENTRIES];
    end
    if (load_out) begin
      out_count  <= res_count;
      out_status <= res_status;
    end
  end

  assign tok[0] = head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ftpc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .commit  (commit),
      .tok_out (tok[i+1])
    );
  end

  assign rsp.valid        = out_valid;
  assign rsp.packet_count = out_count;
  assign rsp.status       = out_status;

endmodule
